// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/wbpm_pkg.sv =====
// types, constants and helpers of the wildcard byte pattern matcher
package wbpm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int SIG_SLOTS   = 16;
  localparam int PAT_LIMIT   = (MAX_PATTERN < SIG_SLOTS) ? MAX_PATTERN : SIG_SLOTS;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 64;
  localparam int LEN_W       = 5;
  localparam int MASK_W      = 16;
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int HOLD_W      = $clog2(PAT_LIMIT);
  localparam int SIG_IDX_W   = $clog2(SIG_SLOTS);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_FIRST_ONLY   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic care;
  } cell_ctrl_t;

  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = LEN_W'(1);
    end else if (n > LEN_W'(PAT_LIMIT)) begin
      r = LEN_W'(PAT_LIMIT);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/wbpm_cell.sv =====
// one window cell: holds a byte, compares the incoming byte against its signature byte; hits on any byte when not cared
module wbpm_cell (
  input  logic                       clk,
  input  wbpm_pkg::cell_ctrl_t       ctrl,
  input  logic [wbpm_pkg::BYTE_W-1:0] byte_in,
  input  logic [wbpm_pkg::BYTE_W-1:0] sig_byte,
  output logic [wbpm_pkg::BYTE_W-1:0] byte_out,
  output logic                       hit
);
  import wbpm_pkg::*;

  logic [BYTE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign hit      = !ctrl.care || (byte_in == sig_byte);

endmodule

// ===== hw/rtl/wildcard_byte_pattern_matcher.sv =====
// Wildcard byte pattern matcher, top level. Takes one byte per cycle: a transfer on the input
// channel can happen every clock, and a match shows on the output channel in the cycle after
// the byte that completes it. The rate is set by the row of window cells, each of which shifts
// its byte to its neighbor and compares the incoming byte against its signature position in the
// same cycle; a one-entry output register decouples the two channels, so input stalls only
// while a result waits and the output is not ready. Configuration writes take effect on the
// next clock. Users must make them while no transfer is in flight; the block doesn't check it.
`include "assert_macros.svh"

module wildcard_byte_pattern_matcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [wbpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbpm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [wbpm_pkg::BYTE_W-1:0]      data_byte,
  input  logic [wbpm_pkg::ADDR_W-1:0]      byte_address,
  input  logic                             new_region,
  input  logic                             new_scan,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wbpm_pkg::ADDR_W-1:0]      match_address
);
  import wbpm_pkg::*;

  logic [63:0]        pattern_low_bytes;
  logic [63:0]        pattern_high_bytes;
  logic [MASK_W-1:0]  care_mask;
  logic [LEN_W-1:0]   pattern_length;
  logic               first_only;

  logic [FILL_W-1:0]  region_fill;
  logic [FILL_W-1:0]  region_fill_next;
  logic [HOLD_W-1:0]  holdoff;
  logic [HOLD_W-1:0]  holdoff_next;
  logic               found_mark;
  logic               found_mark_next;

  logic [2*64-1:0]    sig_flat;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_m1;
  logic               accept;
  logic               region_clear;
  logic [FILL_W-1:0]  fill_base;
  logic [HOLD_W-1:0]  hold_base;
  logic               found_base;
  logic               all_hit;
  logic               fire;

  logic [BYTE_W-1:0]  win [MAX_PATTERN];
  logic [BYTE_W-1:0]  cell_in [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      care_mask          <= '0;
      pattern_length     <= LEN_W'(1);
      first_only         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low_bytes  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high_bytes <= cfg_data;
        REG_CARE_MASK:    care_mask          <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LEN:  pattern_length     <= cfg_data[LEN_W-1:0];
        REG_FIRST_ONLY:   first_only         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sig_flat = {pattern_high_bytes, pattern_low_bytes};
  assign len      = eff_length(pattern_length);
  assign len_m1   = len - LEN_W'(1);

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // cell row, position 0 holds the newest byte
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [LEN_W-1:0]     pos_idx;
    logic [SIG_IDX_W-1:0] sig_idx;
    logic                 in_use;
    cell_ctrl_t           ctrl;

    assign pos_idx    = len_m1 - LEN_W'(j);
    assign sig_idx    = pos_idx[SIG_IDX_W-1:0];
    assign in_use     = LEN_W'(j) < len;
    assign ctrl.shift = accept;
    assign ctrl.care  = in_use && care_mask[sig_idx];

    if (j == 0) begin : g_head
      assign cell_in[j] = data_byte;
    end else begin : g_link
      assign cell_in[j] = win[j-1];
    end

    wbpm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .byte_in  (cell_in[j]),
      .sig_byte (sig_flat[{sig_idx, 3'b000} +: BYTE_W]),
      .byte_out (win[j]),
      .hit      (hit[j])
    );
  end

  assign all_hit = &hit;

  // region, holdoff and found tracking
  always_comb begin
    region_clear = new_region || new_scan;
    fill_base    = region_clear ? '0 : region_fill;
    hold_base    = region_clear ? '0 : holdoff;
    found_base   = new_scan ? 1'b0 : found_mark;

    region_fill_next = fill_base;
    if (int'(fill_base) < MAX_PATTERN) begin
      region_fill_next = fill_base + FILL_W'(1);
    end

    fire = accept && (hold_base == '0) && (int'(region_fill_next) >= int'(len))
           && !(first_only && found_base) && all_hit;

    holdoff_next = '0;
    if (hold_base != '0) begin
      holdoff_next = hold_base - HOLD_W'(1);
    end else if (fire) begin
      holdoff_next = HOLD_W'(len_m1);
    end

    found_mark_next = found_base || fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_fill <= '0;
      holdoff     <= '0;
      found_mark  <= 1'b0;
    end else if (accept) begin
      region_fill <= region_fill_next;
      holdoff     <= holdoff_next;
      found_mark  <= found_mark_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      match_address <= byte_address - ADDR_W'(len_m1);
    end
  end

  `ASSERT_CLK(a_fire_shows_result, fire |=> out_valid, "match not presented")
  `ASSERT_CLK(a_fire_sets_holdoff, fire |=> holdoff == $past(HOLD_W'(len_m1)),
              "holdoff not loaded")
  `ASSERT_CLK(a_first_only_blocks,
              accept && first_only && found_mark && !new_scan |-> !fire,
              "second match in first-only scan")
  `ASSERT_CLK(a_fill_counts, accept |=> region_fill != '0, "fill count not advanced")
  `ASSERT_ALWAYS(a_stall_blocks_input, out_valid && !out_ready |-> !in_ready,
                 "input taken while result waits")

endmodule
